// ===== hw/rtl/ppt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_pkg
// Shared types, widths and constants of the path tracker.
// ----------------------------------------------------------------------------
package ppt_pkg;

    localparam int PATH_DEPTH = 1024;
    localparam int ADDR_W     = $clog2(PATH_DEPTH);
    localparam int CNT_W      = $clog2(PATH_DEPTH + 1);

    localparam int COORD_W    = 32;
    localparam int HEAD_W     = 16;
    localparam int LD_W       = 20;
    localparam int CEIL_W     = 14;
    localparam int CFG_W      = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int LD2_W      = 2 * LD_W;
    localparam int IDX_W      = 10;
    localparam int SPEED_W    = 13;
    localparam int YAW_W      = 16;
    localparam int STATUS_W   = 2;

    localparam int VEC_W      = 44;
    localparam int Z_W        = 22;
    localparam int LY_W       = 61;
    localparam int NUM_W      = 60;
    localparam int KAP_W      = 23;
    localparam int DIV_STEPS  = 22;
    localparam int SAT_SHIFT  = 9;
    localparam int CORDIC_N   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_LOOKAHEAD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING   = 2'd1;

    localparam logic [LD_W-1:0]   LD_RESET   = 20'd32768;
    localparam logic [CEIL_W-1:0] CEIL_RESET = 14'd8192;

    localparam logic [SPEED_W-1:0] SPEED_TOP   = 13'd6963;
    localparam logic [SPEED_W-1:0] SPEED_FLOOR = 13'd3277;
    localparam logic signed [Z_W-1:0] PI_Q16      = 22'sd205887;
    localparam logic signed [Z_W-1:0] HALF_PI_Q16 = 22'sd102944;
    localparam logic signed [16:0]    GAIN_Q16    = 17'sd39797;
    localparam logic [KAP_W-1:0]      KAPPA_SAT   = 23'd4194304;
    localparam logic [12:0]           RECIP_TEN   = 13'd6553;

    localparam logic [15:0] ATAN_Q16 [CORDIC_N] = '{
        16'd51472, 16'd30386, 16'd16055, 16'd8150, 16'd4091, 16'd2047, 16'd1024, 16'd512,
        16'd256,   16'd128,   16'd64,    16'd32,   16'd16,   16'd8,    16'd4,    16'd2
    };

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_TRACK  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_NEAR, S_FAR, S_GRD, S_GWT, S_COR, S_GAIN,
        S_DVS, S_DVW, S_SQR, S_SPD, S_VEL, S_MUL, S_FIN, S_DONE
    } t_state;

    typedef struct packed {
        logic start;
        logic done;
    } t_div_ctl;

endpackage

// ===== hw/rtl/ppt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ppt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/ppt_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_div
// Restoring divider for curvature: quotient = num * 2^13 / den, one bit per
// cycle, saturated when the quotient would reach 2^22.
// ----------------------------------------------------------------------------
module ppt_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ppt_pkg::t_div_ctl           i_ctl,
    output ppt_pkg::t_div_ctl           o_ctl,
    input  logic [ppt_pkg::NUM_W-1:0]   i_num,
    input  logic [ppt_pkg::LD2_W-1:0]   i_den,
    output logic [ppt_pkg::KAP_W-1:0]   o_quo
);
    import ppt_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic                 r_sat;
    logic [4:0]           r_cnt;
    logic [LD2_W-1:0]     r_den;
    logic [LD2_W-1:0]     r_rem;
    logic [DIV_STEPS-1:0] r_nb;
    logic [DIV_STEPS-1:0] r_q;
    logic [LD2_W:0]       w_trial;
    logic                 w_ge;
    logic                 w_sat;

    assign w_trial = {r_rem, r_nb[DIV_STEPS-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_sat   = i_num >= NUM_W'({i_den, {SAT_SHIFT{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_den <= i_den;
                r_sat <= w_sat;
                r_rem <= LD2_W'(i_num >> SAT_SHIFT);
                r_nb  <= {i_num[SAT_SHIFT-1:0], {(DIV_STEPS-SAT_SHIFT){1'b0}}};
                r_q   <= '0;
                r_cnt <= '0;
                r_busy <= !w_sat;
                r_done <= w_sat;
            end else if (r_busy) begin
                r_rem <= w_ge ? LD2_W'(w_trial - {1'b0, r_den}) : LD2_W'(w_trial);
                r_q   <= {r_q[DIV_STEPS-2:0], w_ge};
                r_nb  <= {r_nb[DIV_STEPS-2:0], 1'b0};
                r_cnt <= 5'(r_cnt + 1'b1);
                if (r_cnt == 5'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_ctl.start = 1'b0;
    assign o_ctl.done  = r_done;
    assign o_quo       = r_sat ? KAPPA_SAT : {1'b0, r_q};
endmodule

// ===== hw/rtl/pure_pursuit_path_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pure_pursuit_path_tracker
// Waypoint store with nearest / lookahead search and speed, yaw-rate output.
// ----------------------------------------------------------------------------
// Usage:
//  Request channel (i_req_valid / o_req_stall) carries a command and a
//  coordinate pair plus heading. Clear and append write one waypoint into the
//  x/y RAMs; track runs a query on the stored path.
//  Response channel (o_rsp_valid / i_rsp_stall) returns one result per request.
//  Load and empty-path requests go from idle straight to S_DONE.
//  A track request runs two streamed passes over the RAM read port (one
//  waypoint per cycle, with the read pipeline drained after each), 16 CORDIC
//  steps, a bit-serial divider and the speed steps.
//  One request is in work at a time; o_req_stall is high while it runs.
//  The output register holds a result while i_rsp_stall is high; the next
//  request is taken as soon as the result has moved into that register.
//  Reset empties the path and loads the default lookahead (0.5 m) and speed
//  ceiling (2.0 m/s). Configuration writes are taken at any cycle.
// ----------------------------------------------------------------------------
module pure_pursuit_path_tracker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_req_valid,
    output logic                                o_req_stall,
    input  logic [1:0]                          i_command,
    input  logic signed [ppt_pkg::COORD_W-1:0]  i_coord_x,
    input  logic signed [ppt_pkg::COORD_W-1:0]  i_coord_y,
    input  logic signed [ppt_pkg::HEAD_W-1:0]   i_heading,
    output logic                                o_rsp_valid,
    input  logic                                i_rsp_stall,
    output logic [ppt_pkg::SPEED_W-1:0]         o_speed_cmd,
    output logic signed [ppt_pkg::YAW_W-1:0]    o_yaw_rate_cmd,
    output logic [ppt_pkg::IDX_W-1:0]           o_closest_point,
    output logic [ppt_pkg::IDX_W-1:0]           o_goal_point,
    output logic [ppt_pkg::STATUS_W-1:0]        o_status,
    input  logic                                i_cfg_we,
    input  logic [ppt_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ppt_pkg::CFG_W-1:0]           i_cfg_data
);
    import ppt_pkg::*;

    t_state r_state, n_state;

    logic [LD_W-1:0]   r_ld;
    logic [CEIL_W-1:0] r_ceil;
    logic [CNT_W-1:0]  r_count;
    logic [LD2_W-1:0]  r_ld2;

    logic signed [COORD_W-1:0] r_cx, r_cy;
    logic signed [HEAD_W-1:0]  r_hd;

    logic   w_accept;
    logic   w_load_out;
    t_cmd   w_cmd;
    logic   w_full;

    // RAM ports
    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    logic [ADDR_W-1:0]  w_raddr;
    logic [COORD_W-1:0] w_rx, w_ry;

    // scan pipeline
    logic [CNT_W-1:0]  r_iss;
    logic              r_issue;
    logic              r_vb, r_vc, r_vd;
    logic [ADDR_W-1:0] r_ib, r_ic, r_id;
    logic [31:0]       r_ax, r_ay;
    logic [63:0]       r_sx, r_sy;
    logic [64:0]       w_d;
    logic [64:0]       r_bd;
    logic              r_have, r_found;
    logic [ADDR_W-1:0] r_best, r_goal;
    logic              w_drained;
    logic signed [32:0] w_dx, w_dy;
    logic [32:0]        w_adx, w_ady;

    // rotation and speed path
    logic signed [VEC_W-1:0] r_x, r_y, w_x0, w_y0, w_xs, w_ys;
    logic signed [Z_W-1:0]   r_z, w_z0, w_at;
    logic [3:0]              r_step;
    logic signed [LY_W-1:0]  r_ly;
    logic [LY_W-1:0]         w_lym;
    logic                    r_neg;
    logic [LD2_W-1:0]        w_den;
    logic [KAP_W-1:0]        r_kap, w_quo;
    logic [45:0]             r_k2;
    logic [17:0]             w_a;
    logic [30:0]             w_qm;
    logic [14:0]             w_q0;
    logic [17:0]             w_rem;
    logic [13:0]             r_dec;
    logic [CEIL_W-1:0]       w_v;
    logic [SPEED_W-1:0]      r_v;
    logic [35:0]             r_prod;
    logic [16:0]             w_om, w_lim, w_omc;
    t_div_ctl                w_div_in, w_div_out;

    // result and output registers
    logic [SPEED_W-1:0]        r_res_speed;
    logic signed [YAW_W-1:0]   r_res_yaw;
    logic [IDX_W-1:0]          r_res_close, r_res_goal;
    logic [STATUS_W-1:0]       r_res_status;
    logic                      r_o_valid;
    logic [SPEED_W-1:0]        r_o_speed;
    logic signed [YAW_W-1:0]   r_o_yaw;
    logic [IDX_W-1:0]          r_o_close, r_o_goal;
    logic [STATUS_W-1:0]       r_o_status;

    assign w_cmd    = t_cmd'(i_command);
    assign w_accept = i_req_valid && (r_state == S_IDLE);
    assign w_full   = r_count >= CNT_W'(PATH_DEPTH);

    // ---------------- waypoint store ----------------
    assign w_we    = w_accept && ((w_cmd == CMD_CLEAR) || (w_cmd == CMD_APPEND && !w_full));
    assign w_waddr = (w_cmd == CMD_CLEAR) ? '0 : r_count[ADDR_W-1:0];
    assign w_raddr = (r_state == S_GRD) ? r_goal : r_iss[ADDR_W-1:0];

    ppt_ram #(.WIDTH(COORD_W), .DEPTH(PATH_DEPTH)) u_ram_x (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_coord_x),
        .i_raddr (w_raddr),
        .o_rdata (w_rx)
    );

    ppt_ram #(.WIDTH(COORD_W), .DEPTH(PATH_DEPTH)) u_ram_y (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_coord_y),
        .i_raddr (w_raddr),
        .o_rdata (w_ry)
    );

    // ---------------- offsets and squared distance ----------------
    assign w_dx  = {w_rx[COORD_W-1], w_rx} - {r_cx[COORD_W-1], r_cx};
    assign w_dy  = {w_ry[COORD_W-1], w_ry} - {r_cy[COORD_W-1], r_cy};
    assign w_adx = w_dx[32] ? 33'(-w_dx) : 33'(w_dx);
    assign w_ady = w_dy[32] ? 33'(-w_dy) : 33'(w_dy);
    assign w_d   = {1'b0, r_sx} + {1'b0, r_sy};
    assign w_drained = !r_issue && !r_vb && !r_vc && !r_vd;

    // ---------------- rotation setup and CORDIC step ----------------
    assign w_x0 = {{3{w_dx[32]}}, w_dx, 8'b0};
    assign w_y0 = {{3{w_dy[32]}}, w_dy, 8'b0};
    assign w_z0 = -{{3{r_hd[HEAD_W-1]}}, r_hd, 3'b0};
    assign w_xs = r_x >>> r_step;
    assign w_ys = r_y >>> r_step;
    assign w_at = $signed({6'b0, ATAN_Q16[r_step]});

    // ---------------- curvature and speed ----------------
    assign w_lym = r_ly[LY_W-1] ? LY_W'(-r_ly) : LY_W'(r_ly);
    assign w_den = (r_ld2 == '0) ? LD2_W'(1) : r_ld2;
    assign w_div_in.start = (r_state == S_DVS);
    assign w_div_in.done  = 1'b0;

    ppt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_in),
        .o_ctl   (w_div_out),
        .i_num   (w_lym[NUM_W-1:0]),
        .i_den   (w_den),
        .o_quo   (w_quo)
    );

    // divide by ten: reciprocal estimate is low by at most one
    assign w_a   = 18'(r_k2[45:28]) + 18'd5;
    assign w_qm  = w_a * RECIP_TEN;
    assign w_q0  = w_qm[30:16];
    assign w_rem = w_a - 18'(w_q0) * 18'd10;

    always_comb begin
        w_v = (r_dec >= 14'(SPEED_TOP)) ? '0 : CEIL_W'(14'(SPEED_TOP) - r_dec);
        if (w_v > r_ceil) w_v = r_ceil;
        if (w_v < CEIL_W'(SPEED_FLOOR)) w_v = CEIL_W'(SPEED_FLOOR);
        if (w_v > CEIL_W'(SPEED_TOP)) w_v = CEIL_W'(SPEED_TOP);
    end

    assign w_om  = 17'((r_prod + 36'(1 << 19)) >> 20);
    assign w_lim = 17'(r_v) * 17'd3;
    assign w_omc = (w_om > w_lim) ? w_lim : w_om;

    // ---------------- control ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        w_load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_cmd == CMD_TRACK && r_count != '0) n_state = S_NEAR;
                    else n_state = S_DONE;
                end
            end
            S_NEAR: if (w_drained) n_state = S_FAR;
            S_FAR:  if (w_drained) n_state = S_GRD;
            S_GRD:  n_state = S_GWT;
            S_GWT:  n_state = S_COR;
            S_COR:  if (r_step == 4'(CORDIC_N - 1)) n_state = S_GAIN;
            S_GAIN: n_state = S_DVS;
            S_DVS:  n_state = S_DVW;
            S_DVW:  if (w_div_out.done) n_state = S_SQR;
            S_SQR:  n_state = S_SPD;
            S_SPD:  n_state = S_VEL;
            S_VEL:  n_state = S_MUL;
            S_MUL:  n_state = S_FIN;
            S_FIN:  n_state = S_DONE;
            S_DONE: begin
                if (!r_o_valid || !i_rsp_stall) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_req_stall = (r_state != S_IDLE);

    // configuration and path count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ld    <= LD_RESET;
            r_ceil  <= CEIL_RESET;
            r_count <= '0;
        end else begin
            if (i_cfg_we && i_cfg_index == CFG_LOOKAHEAD) r_ld <= i_cfg_data;
            if (i_cfg_we && i_cfg_index == CFG_CEILING) r_ceil <= i_cfg_data[CEIL_W-1:0];
            if (w_accept && w_cmd == CMD_CLEAR) begin
                r_count <= CNT_W'(1);
            end else if (w_accept && w_cmd == CMD_APPEND && !w_full) begin
                r_count <= CNT_W'(r_count + 1'b1);
            end
        end
    end

    // scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= 1'b0;
            r_vb    <= 1'b0;
            r_vc    <= 1'b0;
            r_vd    <= 1'b0;
        end else begin
            r_vb <= r_issue;
            r_vc <= r_vb;
            r_vd <= r_vc;
            if (r_issue) begin
                r_iss <= CNT_W'(r_iss + 1'b1);
                if (CNT_W'(r_iss + 1'b1) == r_count) r_issue <= 1'b0;
            end
            if (w_accept && w_cmd == CMD_TRACK && r_count != '0) begin
                r_iss   <= '0;
                r_issue <= 1'b1;
            end
            if (r_state == S_NEAR && w_drained) begin
                r_iss   <= CNT_W'(r_best);
                r_issue <= 1'b1;
            end
            // stop the second pass at the first waypoint at or beyond lookahead
            if (r_state == S_FAR && r_vd && !r_found && (w_d >= 65'(r_ld2))) begin
                r_issue <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_ib <= r_iss[ADDR_W-1:0];
        r_ic <= r_ib;
        r_id <= r_ic;
        r_ax <= w_adx[31:0];
        r_ay <= w_ady[31:0];
        r_sx <= r_ax * r_ax;
        r_sy <= r_ay * r_ay;

        if (w_accept) begin
            r_cx  <= i_coord_x;
            r_cy  <= i_coord_y;
            r_hd  <= i_heading;
            r_ld2 <= r_ld * r_ld;
            r_have  <= 1'b0;
            r_found <= 1'b0;
            r_res_speed  <= '0;
            r_res_yaw    <= '0;
            r_res_close  <= '0;
            r_res_goal   <= '0;
            r_res_status <= ST_OK;
            if (w_cmd == CMD_APPEND && w_full) r_res_status <= ST_FULL;
            if (w_cmd == CMD_TRACK && r_count == '0) r_res_status <= ST_EMPTY;
        end

        // nearest: first strict minimum
        if (r_state == S_NEAR && r_vd && (!r_have || w_d < r_bd)) begin
            r_best <= r_id;
            r_bd   <= w_d;
            r_have <= 1'b1;
        end
        if (r_state == S_FAR) begin
            if (r_vd && !r_found && (w_d >= 65'(r_ld2))) begin
                r_goal  <= r_id;
                r_found <= 1'b1;
            end
            if (w_drained && !r_found) r_goal <= ADDR_W'(r_count - 1'b1);
        end

        if (r_state == S_GWT) begin
            r_step <= '0;
            if (w_z0 > HALF_PI_Q16) begin
                r_x <= -w_x0;
                r_y <= -w_y0;
                r_z <= w_z0 - PI_Q16;
            end else if (w_z0 < -HALF_PI_Q16) begin
                r_x <= -w_x0;
                r_y <= -w_y0;
                r_z <= w_z0 + PI_Q16;
            end else begin
                r_x <= w_x0;
                r_y <= w_y0;
                r_z <= w_z0;
            end
        end
        if (r_state == S_COR) begin
            r_step <= 4'(r_step + 1'b1);
            if (r_z >= 0) begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_at;
            end
        end
        if (r_state == S_GAIN) r_ly <= r_y * GAIN_Q16;
        if (r_state == S_DVS) r_neg <= r_ly[LY_W-1];
        if (r_state == S_DVW && w_div_out.done) r_kap <= w_quo;
        if (r_state == S_SQR) r_k2 <= r_kap * r_kap;
        if (r_state == S_SPD) r_dec <= (w_rem >= 18'd10) ? 14'(w_q0 + 1'b1) : 14'(w_q0);
        if (r_state == S_VEL) r_v <= w_v[SPEED_W-1:0];
        if (r_state == S_MUL) r_prod <= r_v * r_kap;
        if (r_state == S_FIN) begin
            r_res_speed  <= r_v;
            r_res_yaw    <= r_neg ? YAW_W'(-w_omc) : YAW_W'(w_omc);
            r_res_close  <= IDX_W'(r_best);
            r_res_goal   <= IDX_W'(r_goal);
            r_res_status <= ST_OK;
        end

        if (w_load_out) begin
            r_o_speed  <= r_res_speed;
            r_o_yaw    <= r_res_yaw;
            r_o_close  <= r_res_close;
            r_o_goal   <= r_res_goal;
            r_o_status <= r_res_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_load_out) begin
            r_o_valid <= 1'b1;
        end else if (!i_rsp_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    assign o_rsp_valid     = r_o_valid;
    assign o_speed_cmd     = r_o_speed;
    assign o_yaw_rate_cmd  = r_o_yaw;
    assign o_closest_point = r_o_close;
    assign o_goal_point    = r_o_goal;
    assign o_status        = r_o_status;

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(PATH_DEPTH))
        else $error("waypoint count beyond store depth");

    a_goal_after_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_GRD |-> r_goal >= r_best)
        else $error("goal index before nearest index");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_status == ST_EMPTY |-> o_speed_cmd == '0 && o_yaw_rate_cmd == '0)
        else $error("empty path result carries a command");

    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FIN |-> r_v >= SPEED_FLOOR && r_v <= SPEED_TOP)
        else $error("speed outside clamp range");

    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_req_stall)
        else $error("request taken without leaving idle");
endmodule

// ===== test/ppt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_checker
// Watches the request, response and register ports of the path tracker,
// keeps its own copy of the waypoint path and registers, predicts each
// response and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module ppt_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_req_valid,
    input  logic                                i_req_stall,
    input  logic [1:0]                          i_command,
    input  logic signed [ppt_pkg::COORD_W-1:0]  i_coord_x,
    input  logic signed [ppt_pkg::COORD_W-1:0]  i_coord_y,
    input  logic signed [ppt_pkg::HEAD_W-1:0]   i_heading,
    input  logic                                i_rsp_valid,
    input  logic                                i_rsp_stall,
    input  logic [ppt_pkg::SPEED_W-1:0]         i_speed_cmd,
    input  logic signed [ppt_pkg::YAW_W-1:0]    i_yaw_rate_cmd,
    input  logic [ppt_pkg::IDX_W-1:0]           i_closest_point,
    input  logic [ppt_pkg::IDX_W-1:0]           i_goal_point,
    input  logic [ppt_pkg::STATUS_W-1:0]        i_status,
    input  logic                                i_cfg_we,
    input  logic [ppt_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ppt_pkg::CFG_W-1:0]           i_cfg_data,
    output int                                  o_errors,
    output int                                  o_pending
);
    import ppt_pkg::*;

    typedef struct packed {
        logic [SPEED_W-1:0]  speed;
        logic [YAW_W-1:0]    yaw;
        logic [IDX_W-1:0]    nearest;
        logic [IDX_W-1:0]    goal;
        logic [STATUS_W-1:0] status;
    } t_command_out;

    localparam int ATAN_TAB [CORDIC_N] = '{
        51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };

    logic signed [COORD_W-1:0] path_x [PATH_DEPTH];
    logic signed [COORD_W-1:0] path_y [PATH_DEPTH];
    int                        path_len;
    logic [LD_W-1:0]           lookahead;
    logic [CEIL_W-1:0]         ceiling;
    t_command_out              expected_out [$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    // exact squared distance from waypoint i to the vehicle
    function automatic logic [65:0] dist_sq(int i, longint cx, longint cy);
        longint      dx;
        longint      dy;
        logic [65:0] ax;
        logic [65:0] ay;
        dx = longint'(path_x[i]) - cx;
        dy = longint'(path_y[i]) - cy;
        ax = (dx < 0) ? 66'(-dx) : 66'(dx);
        ay = (dy < 0) ? 66'(-dy) : 66'(dy);
        return ax * ax + ay * ay;
    endfunction

    function automatic t_command_out track_pose(longint cx, longint cy, longint hd);
        t_command_out r;
        int           nearest;
        int           goal;
        logic [65:0]  best_d;
        logic [65:0]  d;
        logic [65:0]  ld2;
        longint       x, y, z, t, xs, ys, ly, lym, dv, kap, dec, v, om;
        logic         neg;
        r = '0;
        nearest = 0;
        best_d = dist_sq(0, cx, cy);
        for (int i = 1; i < path_len; i++) begin
            d = dist_sq(i, cx, cy);
            if (d < best_d) begin
                best_d = d;
                nearest = i;
            end
        end
        ld2 = 66'(lookahead) * 66'(lookahead);
        goal = path_len - 1;
        for (int i = nearest; i < path_len; i++) begin
            if (dist_sq(i, cx, cy) >= ld2) begin
                goal = i;
                break;
            end
        end
        // rotate the goal offset into the vehicle frame
        x = (longint'(path_x[goal]) - cx) * 256;
        y = (longint'(path_y[goal]) - cy) * 256;
        z = -hd * 8;
        if (z > longint'(HALF_PI_Q16)) begin
            x = -x; y = -y; z = z - longint'(PI_Q16);
        end else if (z < -longint'(HALF_PI_Q16)) begin
            x = -x; y = -y; z = z + longint'(PI_Q16);
        end
        for (int i = 0; i < CORDIC_N; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                t = x - ys; y = y + xs; z = z - ATAN_TAB[i];
            end else begin
                t = x + ys; y = y - xs; z = z + ATAN_TAB[i];
            end
            x = t;
        end
        ly = y * longint'(GAIN_Q16);
        neg = ly < 0;
        lym = neg ? -ly : ly;
        dv = (ld2 == 0) ? 1 : longint'(ld2);
        if (lym >= dv * 512)
            kap = longint'(KAPPA_SAT);
        else
            kap = (lym * 8192) / dv;
        dec = (kap * kap + 5 * (64'd1 << 28)) / (10 * (64'd1 << 28));
        v = (dec >= longint'(SPEED_TOP)) ? 0 : longint'(SPEED_TOP) - dec;
        if (v > longint'(ceiling)) v = longint'(ceiling);
        if (v < longint'(SPEED_FLOOR)) v = longint'(SPEED_FLOOR);
        if (v > longint'(SPEED_TOP)) v = longint'(SPEED_TOP);
        om = (v * kap + (64'd1 << 19)) >>> 20;
        if (om > 3 * v) om = 3 * v;
        r.speed   = SPEED_W'(v);
        r.yaw     = YAW_W'(neg ? -om : om);
        r.nearest = IDX_W'(nearest);
        r.goal    = IDX_W'(goal);
        r.status  = ST_OK;
        return r;
    endfunction

    function automatic t_command_out apply_command(logic [1:0] cmd, longint cx,
                                                   longint cy, longint hd);
        t_command_out r;
        r = '0;
        case (t_cmd'(cmd))
            CMD_CLEAR, CMD_APPEND: begin
                if (t_cmd'(cmd) == CMD_CLEAR)
                    path_len = 0;
                if (path_len >= PATH_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    path_x[path_len] = COORD_W'(cx);
                    path_y[path_len] = COORD_W'(cy);
                    path_len++;
                end
            end
            CMD_TRACK: begin
                if (path_len == 0)
                    r.status = ST_EMPTY;
                else
                    r = track_pose(cx, cy, hd);
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report(string field, longint got, longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_command_out want;
        if (!i_rst_n) begin
            path_len = 0;
            lookahead = LD_RESET;
            ceiling = CEIL_RESET;
            expected_out.delete();
            o_pending = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_LOOKAHEAD)
                    lookahead = i_cfg_data[LD_W-1:0];
                else if (i_cfg_index == CFG_CEILING)
                    ceiling = i_cfg_data[CEIL_W-1:0];
            end
            if (i_rsp_valid && !i_rsp_stall) begin
                if (expected_out.size() == 0) begin
                    report("unexpected responses", 1, 0);
                end else begin
                    want = expected_out.pop_front();
                    if (i_speed_cmd !== want.speed)
                        report("speed_cmd", i_speed_cmd, want.speed);
                    if (i_yaw_rate_cmd !== $signed(want.yaw))
                        report("yaw_rate_cmd", i_yaw_rate_cmd, $signed(want.yaw));
                    if (i_closest_point !== want.nearest)
                        report("closest_point", i_closest_point, want.nearest);
                    if (i_goal_point !== want.goal)
                        report("goal_point", i_goal_point, want.goal);
                    if (i_status !== want.status)
                        report("status", i_status, want.status);
                end
            end
            if (i_req_valid && !i_req_stall)
                expected_out.push_back(apply_command(i_command, longint'(i_coord_x),
                    longint'(i_coord_y), longint'(i_heading)));
            o_pending = expected_out.size();
        end
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives waypoint loads and pose queries into the path tracker under several
// register settings and idle patterns; the checker predicts every response.
// ----------------------------------------------------------------------------
module tb;
    import ppt_pkg::*;

    localparam int WATCHDOG_LIMIT = 12000;
    localparam int HOLD_CYCLES    = 300;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_req_valid;
    logic                       o_req_stall;
    logic [1:0]                 i_command;
    logic signed [COORD_W-1:0]  i_coord_x;
    logic signed [COORD_W-1:0]  i_coord_y;
    logic signed [HEAD_W-1:0]   i_heading;
    logic                       o_rsp_valid;
    logic                       i_rsp_stall;
    logic [SPEED_W-1:0]         o_speed_cmd;
    logic signed [YAW_W-1:0]    o_yaw_rate_cmd;
    logic [IDX_W-1:0]           o_closest_point;
    logic [IDX_W-1:0]           o_goal_point;
    logic [STATUS_W-1:0]        o_status;
    logic                       i_cfg_we;
    logic [CFG_IDX_W-1:0]       i_cfg_index;
    logic [CFG_W-1:0]           i_cfg_data;

    int   error_count;
    int   pending_count;
    int   send_idle_pct;
    int   stall_pct;
    logic hold_go;
    logic hold_seen;
    int   hold_cnt;
    int   idle_cycles;
    int   requests_sent;
    int   settings_used;
    int   path_x [64];
    int   path_y [64];

    pure_pursuit_path_tracker DUT (.*);

    ppt_checker u_checker (
        .i_clk, .i_rst_n, .i_req_valid,
        .i_req_stall     (o_req_stall),
        .i_command, .i_coord_x, .i_coord_y, .i_heading,
        .i_rsp_valid     (o_rsp_valid),
        .i_rsp_stall,
        .i_speed_cmd     (o_speed_cmd),
        .i_yaw_rate_cmd  (o_yaw_rate_cmd),
        .i_closest_point (o_closest_point),
        .i_goal_point    (o_goal_point),
        .i_status        (o_status),
        .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .o_errors        (error_count),
        .o_pending       (pending_count)
    );

    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    // receiver: random stall, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_cnt > 0) begin
            i_rsp_stall <= 1'b1;
            hold_cnt <= hold_cnt - 1;
        end else if (hold_go && !hold_seen) begin
            hold_seen <= 1'b1;
            hold_cnt <= HOLD_CYCLES;
            i_rsp_stall <= 1'b1;
        end else begin
            i_rsp_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_req_valid && !o_req_stall) || (o_rsp_valid && !i_rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired at %0t", $realtime);
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_request(t_cmd cmd, int x, int y, int hd);
        logic taken;
        while ($urandom_range(99) < send_idle_pct) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_command   <= cmd;
        i_coord_x   <= x;
        i_coord_y   <= y;
        i_heading   <= HEAD_W'(hd);
        requests_sent++;
        do begin
            @(negedge i_clk);
            taken = !o_req_stall;
            @(posedge i_clk);
        end while (!taken);
    endtask

    // hold the request side until every response is back
    task automatic drain();
        i_req_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic int rand_heading();
        return int'($urandom_range(51472)) - 25736;
    endfunction

    // load a path of random shape, then query poses along it
    task automatic run_path(int npts, int ntrack);
        int step;
        int k;
        step = 1 << $urandom_range(17, 8);
        path_x[0] = ($urandom_range(3) == 0) ? int'($urandom) : int'($urandom) >>> 12;
        path_y[0] = ($urandom_range(3) == 0) ? int'($urandom) : int'($urandom) >>> 12;
        for (int i = 1; i < npts; i++) begin
            path_x[i] = path_x[i-1] + int'($urandom_range(2 * step)) - step / 2;
            path_y[i] = path_y[i-1] + int'($urandom_range(2 * step)) - step;
        end
        for (int i = 0; i < npts; i++)
            send_request((i == 0) ? CMD_CLEAR : CMD_APPEND, path_x[i], path_y[i], 0);
        for (int j = 0; j < ntrack; j++) begin
            k = $urandom_range(npts - 1);
            send_request(CMD_TRACK, path_x[k] + int'($urandom_range(4 * step)) - 2 * step,
                         path_y[k] + int'($urandom_range(4 * step)) - 2 * step,
                         rand_heading());
        end
    endtask

    task automatic run_noise();
        send_request(t_cmd'($urandom_range(3)), int'($urandom), int'($urandom),
                     rand_heading());
    endtask

    initial begin
        logic [LD_W-1:0]   ld_set [8];
        logic [CEIL_W-1:0] ceil_set [8];
        int                phase_start;
        ld_set   = '{20'd32768, 20'd0, 20'd1, 20'd655360, 20'hFFFFF, 20'd131072,
                     20'd12345, 20'd400000};
        ceil_set = '{14'd8192, 14'd16383, 14'd0, 14'd6963, 14'd3000, 14'd5000,
                     14'd3277, 14'd16000};
        i_rst_n       <= 1'b0;
        i_req_valid   <= 1'b0;
        i_command     <= CMD_NONE;
        i_coord_x     <= '0;
        i_coord_y     <= '0;
        i_heading     <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        i_rsp_stall   <= 1'b0;
        hold_go       = 1'b0;
        hold_seen     = 1'b0;
        hold_cnt      = 0;
        idle_cycles   = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        requests_sent = 0;
        settings_used = 1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty path, unused command, extremes, heading limits
        send_request(CMD_TRACK, 0, 0, 0);
        send_request(CMD_NONE, -1, -1, -1);
        send_request(CMD_APPEND, 32'sh7FFFFFFF, 32'sh80000000, 0);
        send_request(CMD_APPEND, 32'sh80000000, 32'sh7FFFFFFF, 0);
        send_request(CMD_TRACK, 32'sh80000000, 32'sh80000000, 25736);
        send_request(CMD_TRACK, 32'sh7FFFFFFF, 32'sh7FFFFFFF, -25736);
        send_request(CMD_CLEAR, 0, 0, 0);
        send_request(CMD_APPEND, 65536, 0, 0);
        send_request(CMD_APPEND, 131072, 65536, 0);
        send_request(CMD_APPEND, 131072, 65536, 0);
        send_request(CMD_TRACK, 0, 0, 0);
        send_request(CMD_TRACK, 70000, -3000, 12868);
        send_request(CMD_TRACK, 200000, 200000, -12868);
        send_request(CMD_TRACK, 500000, -500000, 25736);
        send_request(CMD_TRACK, -40000, 30000, -25736);
        drain();
        write_reg(CFG_LOOKAHEAD, '0);
        send_request(CMD_TRACK, 10, 20, 100);
        send_request(CMD_TRACK, 65536, 0, 0);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_LOOKAHEAD, (ph == 7) ? CFG_W'($urandom_range(655360, 1))
                                               : CFG_W'(ld_set[ph]));
            write_reg(CFG_CEILING, (ph == 5) ? CFG_W'($urandom_range(16383))
                                             : CFG_W'(ceil_set[ph]));
            write_reg(2'd2 + CFG_IDX_W'(ph % 2), CFG_W'($urandom));
            settings_used++;
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 62; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 62; end
                default: begin send_idle_pct = 7; stall_pct = 7; end
            endcase
            if (ph == 4)
                hold_go = 1'b1;
            phase_start = requests_sent;
            while (requests_sent - phase_start < 30) begin
                if ($urandom_range(99) < 85)
                    run_path($urandom_range((ph == 6) ? 60 : 12, 1), $urandom_range(4, 1));
                else
                    run_noise();
            end
            drain();
        end

        repeat (20) @(posedge i_clk);
        $display("sent %0d requests across %0d register settings", requests_sent,
                 settings_used);
        $display("covered empty path, zero lookahead, unused commands and all idle modes");
        if (error_count == 0 && pending_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
